### rtl/mrtu_pkg.sv
// mrtu_pkg: shared constants, op codes and the CRC-16 byte update for the
// Modbus RTU write frame encoder. No dependencies.
package mrtu_pkg;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  FC_SINGLE   = 8'h06;
   localparam logic [7:0]  FC_MULTI    = 8'h10;
   localparam logic [7:0]  SLAVE_RESET = 8'h01;

   // Widest item body: write-multiple header is seven data bytes.
   localparam int          MAX_DATA    = 7;
   localparam int          NDATA_W     = $clog2(MAX_DATA + 1);
   localparam int          POS_W       = $clog2(MAX_DATA + 2 + 1);
   localparam int          IDX_W       = $clog2(MAX_DATA);

   typedef enum logic [1:0] {
      OP_SINGLE = 2'd0,
      OP_HEADER = 2'd1,
      OP_DATA   = 2'd2
   } op_type;

   typedef logic [7:0] byte_type;

   // Reflected CRC-16 over one byte, bit at a time.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/mrtu_ifs.sv
// mrtu_ifs: valid/ready channel interfaces for the frame encoder:
// request items, frame bytes and the slave address write. Uses mrtu_pkg.
interface mrtu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] addr;
   logic [15:0] word;
   logic        last;
   modport source (output valid, op, addr, word, last, input ready);
   modport sink   (input valid, op, addr, word, last, output ready);
endinterface

interface mrtu_rsp_if;
   logic                 valid;
   logic                 ready;
   mrtu_pkg::byte_type   frame_byte;
   logic                 end_of_frame;
   logic                 end_of_item;
   modport source (output valid, frame_byte, end_of_frame, end_of_item, input ready);
   modport sink   (input valid, frame_byte, end_of_frame, end_of_item, output ready);
endinterface

interface mrtu_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/modbus_rtu_write_frame_encoder.sv
// modbus_rtu_write_frame_encoder: turns request words into the byte stream
// of Modbus RTU write requests with CRC-16. Uses mrtu_pkg and mrtu_ifs.
//
// Usage:
//  req_if  - one word per request: op (0 write single, 1 write-multiple
//            header, 2 register value), addr, word, last.
//  rsp_if  - one frame byte per transfer, in transmit order, with end_of_frame
//            on the high CRC byte and end_of_item on the last byte of a request.
//  csr_if  - slave address write, always ready; write only while idle.
// Path: with the serializer empty, a taken request is registered in the input
// register and then loaded into the serializer before its first byte is valid.
// Throughput: one byte per cycle while rsp_if.ready is high; a request makes
// 2, 4, 7, 8 or 9 bytes. The byte serializer sets the rate; the input
// register takes the next request while the serializer still drains the
// current one, so the output need not idle between requests.
// Requests that make no bytes (unused op, data word with no open header)
// are dropped on entry.
// Reset: slave address 1, CRC 0xFFFF, no frame open, both stages empty.
// Stall: with rsp_if.ready low the current byte holds; once the input
// register is full, req_if.ready drops until the serializer takes it.
module modbus_rtu_write_frame_encoder (
   input logic          clock,
   input logic          reset,
   mrtu_req_if.sink     req_if,
   mrtu_rsp_if.source   rsp_if,
   mrtu_csr_if.sink     csr_if
);
   import mrtu_pkg::*;

   // config
   logic [7:0]            slave_ff, slave_in;

   // frame tracking at the input side
   logic                  open_ff, open_in;
   logic                  req_fire, req_drop;

   // input register
   logic                  item_valid_ff, item_valid_in;
   logic [1:0]            item_op_ff, item_op_in;
   logic [15:0]           item_addr_ff, item_addr_in;
   logic [15:0]           item_word_ff, item_word_in;
   logic                  item_last_ff, item_last_in;

   // byte serializer
   logic                  ser_valid_ff, ser_valid_in;
   byte_type              ser_data_ff [MAX_DATA];
   byte_type              ser_data_in [MAX_DATA];
   logic [NDATA_W-1:0]    ser_ndata_ff, ser_ndata_in;
   logic                  ser_crc_en_ff, ser_crc_en_in;
   logic [POS_W-1:0]      ser_pos_ff, ser_pos_in;
   logic [15:0]           crc_ff, crc_in;

   // serializer decode
   logic [POS_W-1:0]      ser_total;
   logic                  in_data, is_crc_high, is_last_byte;
   logic                  rsp_fire, load;
   byte_type              cur_byte;

   // next item as loaded into the serializer
   byte_type              ld_data [MAX_DATA];
   logic [NDATA_W-1:0]    ld_ndata;
   logic                  ld_crc_en, ld_new_frame;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !item_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;

   // Drop decision and frame-open tracking, in acceptance order.
   always_comb begin
      req_drop = 1'b0;
      open_in  = open_ff;
      unique case (req_if.op)
         OP_SINGLE: open_in = 1'b0;
         OP_HEADER: open_in = !req_if.last;
         OP_DATA: begin
            req_drop = !open_ff;
            open_in  = open_ff && !req_if.last;
         end
         default: req_drop = 1'b1;
      endcase
      if (!req_fire) begin
         open_in = open_ff;
      end
   end

   always_comb begin
      slave_in = slave_ff;
      if (csr_if.valid && csr_if.ready) begin
         slave_in = csr_if.data;
      end
   end

   // Serializer position decode.
   assign ser_total    = POS_W'(ser_ndata_ff) + (ser_crc_en_ff ? POS_W'(2) : POS_W'(0));
   assign in_data      = ser_pos_ff < POS_W'(ser_ndata_ff);
   assign is_crc_high  = ser_pos_ff == POS_W'(ser_ndata_ff) + POS_W'(1);
   assign is_last_byte = ser_pos_ff == ser_total - POS_W'(1);
   assign rsp_fire     = ser_valid_ff && rsp_if.ready;
   assign load         = item_valid_ff && (!ser_valid_ff || (rsp_fire && is_last_byte));

   always_comb begin
      if (in_data) begin
         cur_byte = ser_data_ff[ser_pos_ff[IDX_W-1:0]];
      end else if (is_crc_high) begin
         cur_byte = crc_ff[15:8];
      end else begin
         cur_byte = crc_ff[7:0];
      end
   end

   assign rsp_if.valid        = ser_valid_ff;
   assign rsp_if.frame_byte   = cur_byte;
   assign rsp_if.end_of_frame = ser_crc_en_ff && is_crc_high;
   assign rsp_if.end_of_item  = is_last_byte;

   // Frame bytes of the waiting item.
   always_comb begin
      for (int i = 0; i < MAX_DATA; i++) begin
         ld_data[i] = '0;
      end
      unique case (item_op_ff)
         OP_SINGLE: begin
            ld_data[0]   = slave_ff;
            ld_data[1]   = FC_SINGLE;
            ld_data[2]   = item_addr_ff[15:8];
            ld_data[3]   = item_addr_ff[7:0];
            ld_data[4]   = item_word_ff[15:8];
            ld_data[5]   = item_word_ff[7:0];
            ld_ndata     = NDATA_W'(6);
            ld_crc_en    = 1'b1;
            ld_new_frame = 1'b1;
         end
         OP_HEADER: begin
            ld_data[0]   = slave_ff;
            ld_data[1]   = FC_MULTI;
            ld_data[2]   = item_addr_ff[15:8];
            ld_data[3]   = item_addr_ff[7:0];
            ld_data[4]   = item_word_ff[15:8];
            ld_data[5]   = item_word_ff[7:0];
            ld_data[6]   = {item_word_ff[6:0], 1'b0};   // byte count = 2 * count
            ld_ndata     = NDATA_W'(7);
            ld_crc_en    = item_last_ff;
            ld_new_frame = 1'b1;
         end
         default: begin
            // data word: continues the open frame's CRC
            ld_data[0]   = item_word_ff[15:8];
            ld_data[1]   = item_word_ff[7:0];
            ld_ndata     = NDATA_W'(2);
            ld_crc_en    = item_last_ff;
            ld_new_frame = 1'b0;
         end
      endcase
   end

   // Input register next state.
   always_comb begin
      item_valid_in = item_valid_ff;
      item_op_in    = item_op_ff;
      item_addr_in  = item_addr_ff;
      item_word_in  = item_word_ff;
      item_last_in  = item_last_ff;
      if (load) begin
         item_valid_in = 1'b0;
      end
      if (req_fire && !req_drop) begin
         item_valid_in = 1'b1;
         item_op_in    = req_if.op;
         item_addr_in  = req_if.addr;
         item_word_in  = req_if.word;
         item_last_in  = req_if.last;
      end
   end

   // Serializer next state; running CRC advances as each data byte leaves.
   always_comb begin
      ser_valid_in  = ser_valid_ff;
      ser_data_in   = ser_data_ff;
      ser_ndata_in  = ser_ndata_ff;
      ser_crc_en_in = ser_crc_en_ff;
      ser_pos_in    = ser_pos_ff;
      crc_in        = crc_ff;

      if (rsp_fire) begin
         if (in_data) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end else if (is_crc_high) begin
            crc_in = CRC_INIT;
         end
         if (is_last_byte) begin
            ser_valid_in = 1'b0;
         end else begin
            ser_pos_in = ser_pos_ff + POS_W'(1);
         end
      end

      if (load) begin
         ser_valid_in  = 1'b1;
         ser_data_in   = ld_data;
         ser_ndata_in  = ld_ndata;
         ser_crc_en_in = ld_crc_en;
         ser_pos_in    = '0;
         if (ld_new_frame) begin
            crc_in = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff      <= SLAVE_RESET;
         open_ff       <= 1'b0;
         item_valid_ff <= 1'b0;
         ser_valid_ff  <= 1'b0;
         ser_pos_ff    <= '0;
         crc_ff        <= CRC_INIT;
      end else begin
         slave_ff      <= slave_in;
         open_ff       <= open_in;
         item_valid_ff <= item_valid_in;
         ser_valid_ff  <= ser_valid_in;
         ser_pos_ff    <= ser_pos_in;
         crc_ff        <= crc_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      item_op_ff    <= item_op_in;
      item_addr_ff  <= item_addr_in;
      item_word_ff  <= item_word_in;
      item_last_ff  <= item_last_in;
      ser_data_ff   <= ser_data_in;
      ser_ndata_ff  <= ser_ndata_in;
      ser_crc_en_ff <= ser_crc_en_in;
   end

endmodule
